@@ hw/rtl/quaternion_rotate_vector_defines.svh @@
// assertion helpers for the rotation pipeline
`ifndef QUATERNION_ROTATE_VECTOR_DEFINES_SVH
`define QUATERNION_ROTATE_VECTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QRV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrv assertion failed");

// next-cycle implication, checked outside reset
`define QRV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrv assertion failed");

`endif

@@ hw/rtl/qrv_pkg.sv @@
package qrv_pkg;

    localparam int QUAT_WIDTH = 16;
    localparam int VEC_WIDTH  = 32;
    localparam int QFRAC      = QUAT_WIDTH - 3;
    localparam int CFG_WIDTH  = 32;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = CFG_WIDTH'(671);

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
        logic signed [QUAT_WIDTH-1:0] quat_w;
        logic signed [VEC_WIDTH-1:0]  vec_x;
        logic signed [VEC_WIDTH-1:0]  vec_y;
        logic signed [VEC_WIDTH-1:0]  vec_z;
    } in_item_t;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] out_x;
        logic signed [VEC_WIDTH-1:0] out_y;
        logic signed [VEC_WIDTH-1:0] out_z;
        logic                        degenerate;
        logic                        saturated;
    } out_item_t;

endpackage

@@ hw/rtl/quaternion_rotate_vector.sv @@
// quaternion vector rotation: each item carries q (Q2.13, any length) and v (Q15.16);
// the result is the vector part of q * (v,0) * conj(q) / |q|^2, divided exactly with
// truncation toward zero and clamped to the Q15.16 range (saturated flags a clamp).
// when |q|^2 is at or below min_length_sq (Q6.26, reset 671) the inverse is taken as
// the identity and degenerate is set. one item is accepted every cycle while the
// output is not stalled; an item passes through stage 1, stage 2, the divider input
// register, the restoring divider (one quotient bit per stage) and the output register.
// the whole pipeline shares one advance enable, so a stalled output freezes every
// stage and in_ready follows it. min_length_sq may only be written while idle.
`include "quaternion_rotate_vector_defines.svh"

module quaternion_rotate_vector (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [qrv_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  qrv_pkg::in_item_t            in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output qrv_pkg::out_item_t           out_item
);
    import qrv_pkg::*;

    localparam int QW   = QUAT_WIDTH;
    localparam int VW   = VEC_WIDTH;
    localparam int PW   = QW + VW + 2;          // components of q * (v,0)
    localparam int RW   = QW + 1;               // negated quaternion terms
    localparam int TW   = PW + RW;              // one partial product
    localparam int AW   = TW + 2;               // sum of four partial products
    localparam int LW   = 2 * QW + 1;           // squared length
    localparam int CMPW = (LW > CFG_WIDTH) ? LW : CFG_WIDTH;
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic [2:0][AW-1:0] rem;
        logic [2:0][VW-1:0] quo;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic [LW-1:0]      d;
        logic               degen;
    } dstage_t;

    logic advance;
    logic [CFG_WIDTH-1:0] cfg_reg;

    // stage 1: q * (v,0) and squared length
    logic                   s1_vld_reg;
    logic signed [PW-1:0]   s1_px_reg, s1_py_reg, s1_pz_reg, s1_pw_reg;
    logic signed [QW-1:0]   s1_qx_reg, s1_qy_reg, s1_qz_reg, s1_qw_reg;
    logic [LW-1:0]          s1_lsq_reg;
    logic signed [PW-1:0]   px_next, py_next, pz_next, pw_next;
    logic signed [LW:0]     lsq_wide;

    // stage 2: partial products of p * r
    logic                   s2_vld_reg;
    logic signed [TW-1:0]   s2_t_reg [0:2][0:3];
    logic [LW-1:0]          s2_d_reg;
    logic                   s2_degen_reg;
    logic                   degen_next;
    logic signed [RW-1:0]   rx, ry, rz, rw;
    logic [LW-1:0]          d_next;

    // stage 3 feeds the divider
    logic                   dv_vld_reg [0:VW];
    dstage_t                dv_reg [0:VW];
    logic signed [AW-1:0]   acc [0:2];
    dstage_t                dv0_next;

    logic                   out_valid_reg;
    out_item_t              out_item_reg;
    out_item_t              out_next;
    logic                   out_at_limit;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_data;
        end
    end

    // stage 1
    always_comb
    begin
        px_next = PW'(in_item.quat_w) * PW'(in_item.vec_x)
                + PW'(in_item.quat_y) * PW'(in_item.vec_z)
                - PW'(in_item.quat_z) * PW'(in_item.vec_y);
        py_next = PW'(in_item.quat_w) * PW'(in_item.vec_y)
                - PW'(in_item.quat_x) * PW'(in_item.vec_z)
                + PW'(in_item.quat_z) * PW'(in_item.vec_x);
        pz_next = PW'(in_item.quat_w) * PW'(in_item.vec_z)
                + PW'(in_item.quat_x) * PW'(in_item.vec_y)
                - PW'(in_item.quat_y) * PW'(in_item.vec_x);
        pw_next = -(PW'(in_item.quat_x) * PW'(in_item.vec_x))
                - PW'(in_item.quat_y) * PW'(in_item.vec_y)
                - PW'(in_item.quat_z) * PW'(in_item.vec_z);
        lsq_wide = (LW+1)'(in_item.quat_x) * (LW+1)'(in_item.quat_x)
                 + (LW+1)'(in_item.quat_y) * (LW+1)'(in_item.quat_y)
                 + (LW+1)'(in_item.quat_z) * (LW+1)'(in_item.quat_z)
                 + (LW+1)'(in_item.quat_w) * (LW+1)'(in_item.quat_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_px_reg  <= px_next;
            s1_py_reg  <= py_next;
            s1_pz_reg  <= pz_next;
            s1_pw_reg  <= pw_next;
            s1_qx_reg  <= in_item.quat_x;
            s1_qy_reg  <= in_item.quat_y;
            s1_qz_reg  <= in_item.quat_z;
            s1_qw_reg  <= in_item.quat_w;
            s1_lsq_reg <= lsq_wide[LW-1:0];
        end
    end

    // stage 2: pick conj(q) or the identity, then multiply out
    always_comb
    begin
        degen_next = (CMPW'(s1_lsq_reg) <= CMPW'(cfg_reg));
        if (degen_next)
        begin
            rx     = '0;
            ry     = '0;
            rz     = '0;
            rw     = RW'(1) << QFRAC;
            d_next = LW'(1) << (2 * QFRAC);
        end
        else
        begin
            rx     = -RW'(s1_qx_reg);
            ry     = -RW'(s1_qy_reg);
            rz     = -RW'(s1_qz_reg);
            rw     = RW'(s1_qw_reg);
            d_next = s1_lsq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_t_reg[0][0] <= TW'(s1_pw_reg) * TW'(rx);
            s2_t_reg[0][1] <= TW'(s1_px_reg) * TW'(rw);
            s2_t_reg[0][2] <= TW'(s1_py_reg) * TW'(rz);
            s2_t_reg[0][3] <= TW'(s1_pz_reg) * TW'(ry);
            s2_t_reg[1][0] <= TW'(s1_pw_reg) * TW'(ry);
            s2_t_reg[1][1] <= TW'(s1_px_reg) * TW'(rz);
            s2_t_reg[1][2] <= TW'(s1_py_reg) * TW'(rw);
            s2_t_reg[1][3] <= TW'(s1_pz_reg) * TW'(rx);
            s2_t_reg[2][0] <= TW'(s1_pw_reg) * TW'(rz);
            s2_t_reg[2][1] <= TW'(s1_px_reg) * TW'(ry);
            s2_t_reg[2][2] <= TW'(s1_py_reg) * TW'(rx);
            s2_t_reg[2][3] <= TW'(s1_pz_reg) * TW'(rw);
            s2_d_reg       <= d_next;
            s2_degen_reg   <= degen_next;
        end
    end

    // stage 3: sums, sign and magnitude, quotient overflow check
    always_comb
    begin
        acc[0] = AW'(s2_t_reg[0][0]) + AW'(s2_t_reg[0][1])
               + AW'(s2_t_reg[0][2]) - AW'(s2_t_reg[0][3]);
        acc[1] = AW'(s2_t_reg[1][0]) - AW'(s2_t_reg[1][1])
               + AW'(s2_t_reg[1][2]) + AW'(s2_t_reg[1][3]);
        acc[2] = AW'(s2_t_reg[2][0]) + AW'(s2_t_reg[2][1])
               - AW'(s2_t_reg[2][2]) + AW'(s2_t_reg[2][3]);
        dv0_next       = '0;
        dv0_next.d     = s2_d_reg;
        dv0_next.degen = s2_degen_reg;
        for (int c = 0; c < 3; c++)
        begin
            dv0_next.neg[c] = acc[c][AW-1];
            dv0_next.rem[c] = acc[c][AW-1] ? unsigned'(-acc[c]) : unsigned'(acc[c]);
            dv0_next.ovf[c] = (dv0_next.rem[c] >= (AW'(s2_d_reg) << VW));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            dv_vld_reg[0] <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_reg[0] <= dv0_next;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar k = 0; k < VW; k++)
    begin : g_div
        localparam int SH = VW - 1 - k;
        dstage_t st_next;

        always_comb
        begin
            st_next = dv_reg[k];
            for (int c = 0; c < 3; c++)
            begin
                if (dv_reg[k].rem[c] >= (AW'(dv_reg[k].d) << SH))
                begin
                    st_next.rem[c]     = dv_reg[k].rem[c] - (AW'(dv_reg[k].d) << SH);
                    st_next.quo[c][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k+1] <= 1'b0;
            end
            else if (advance)
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dv_reg[k+1] <= st_next;
            end
        end
    end

    // sign, clamp and flags
    always_comb
    begin
        logic [2:0]              sat;
        logic signed [VW-1:0]    val [0:2];
        logic [VW-1:0]           q;
        for (int c = 0; c < 3; c++)
        begin
            q = dv_reg[VW].quo[c];
            if (dv_reg[VW].neg[c])
            begin
                sat[c] = dv_reg[VW].ovf[c] || (q[VW-1] && (q[VW-2:0] != '0));
                val[c] = sat[c] ? VMIN : signed'(-q);
            end
            else
            begin
                sat[c] = dv_reg[VW].ovf[c] || q[VW-1];
                val[c] = sat[c] ? VMAX : signed'(q);
            end
        end
        out_next.out_x      = val[0];
        out_next.out_y      = val[1];
        out_next.out_z      = val[2];
        out_next.degenerate = dv_reg[VW].degen;
        out_next.saturated  = |sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dv_vld_reg[VW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // some component of the offered item sits at a range limit
    assign out_at_limit = (out_item.out_x == VMAX) || (out_item.out_x == VMIN)
                       || (out_item.out_y == VMAX) || (out_item.out_y == VMIN)
                       || (out_item.out_z == VMAX) || (out_item.out_z == VMIN);

    `QRV_ASSERT_NXT(a_last_stage_moves, advance && dv_vld_reg[VW], out_valid)
    `QRV_ASSERT_NXT(a_stall_freezes, !advance, out_valid && $stable(dv_vld_reg[VW]))
    `QRV_ASSERT_IMP(a_sat_clamps, out_valid && out_item.saturated, out_at_limit)

endmodule
